>>> rtl/triangle_color_span_shader_core_macros.svh
// assertion macros shared by the span shader rtl
`ifndef TRIANGLE_COLOR_SPAN_SHADER_CORE_MACROS_SVH
`define TRIANGLE_COLOR_SPAN_SHADER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TCSS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TCSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TCSS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define TCSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/tcss_pkg.sv
// types and constants of the triangle color span shader
package tcss_pkg;

   localparam int CHANNELS    = 4;
   localparam int CHAN_W      = 32;
   localparam int COLOR_W     = 16;
   localparam int DIFF_W      = 17;
   localparam int GAIN_W      = 32;
   localparam int UV_W        = 41;
   localparam int UV_FRAC     = 17;
   localparam int XY_W        = 12;
   localparam int COUNT_W     = 7;
   localparam int ARGB_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PAIR_W      = 4;
   localparam int COLOR_SHIFT = 8;
   localparam int STEP_SHIFT  = 7;
   localparam int PIX_SHIFT   = 24;
   localparam int PIX_W       = CHAN_W + 9;

   localparam logic [PAIR_W-1:0] PAIR_U           = 4'd0;
   localparam logic [PAIR_W-1:0] PAIR_V           = 4'd1;
   localparam logic [PAIR_W-1:0] PAIR_FIRST_COLOR = 4'd2;
   localparam logic [PAIR_W-1:0] PAIR_LAST        = 4'd9;

   typedef logic signed [CHAN_W-1:0] chan_type;

   localparam chan_type CHAN_MAX = {1'b0, {(CHAN_W-1){1'b1}}};
   localparam chan_type CHAN_MIN = {1'b1, {(CHAN_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_U_GAINS    = 3'd0,
      CSR_V_GAINS    = 3'd1,
      CSR_OFFSETS    = 3'd2,
      CSR_COLOR_BASE = 3'd3,
      CSR_COLOR_U    = 3'd4,
      CSR_COLOR_V    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_WB,
      ST_PUSH
   } setup_state_type;

   typedef logic [0:CHANNELS-1][COLOR_W-1:0] color_set_type;
   typedef logic [0:CHANNELS-1][CHAN_W-1:0]  chan_set_type;

   typedef struct packed {
      chan_set_type        color;
      chan_set_type        step;
      logic [COUNT_W-1:0]  count;
   } span_entry_type;

endpackage

>>> rtl/triangle_color_span_shader_core.sv
// pixels leave at one per cycle within a span while rsp_stall is low
// setup runs ten product pairs per span through one shared multiplier
// a span queue lets setup take a new span while earlier spans still emit pixels
// reset: synchronous active high, clears control state and all config registers to zero
// top level of the triangle color span shader
module triangle_color_span_shader_core
   import tcss_pkg::*;
#(
   parameter int MAX_SPAN    = 64,
   parameter int COORD_BITS  = 12,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [XY_W-1:0]        req_start_x,
   input  logic [XY_W-1:0]        req_row_y,
   input  logic [COUNT_W-1:0]     req_pixel_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ARGB_W-1:0]      rsp_pixel_argb,
   output logic                   rsp_last_pixel,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic           push_valid, queue_full, pop_valid, pop;
   span_entry_type push_entry, pop_entry;

   tcss_setup #(
      .MAX_SPAN   (MAX_SPAN),
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_x     (req_start_x),
      .req_row_y       (req_row_y),
      .req_pixel_count (req_pixel_count),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .push_valid      (push_valid),
      .push_entry      (push_entry),
      .queue_full      (queue_full)
   );

   tcss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   tcss_pixel #(
      .MAX_SPAN (MAX_SPAN)
   ) u_pixel (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (pop_valid),
      .q_entry        (pop_entry),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_argb (rsp_pixel_argb),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

>>> rtl/tcss_setup.sv
// span setup: config registers and start color / step sequencer on one multiplier
`include "triangle_color_span_shader_core_macros.svh"
module tcss_setup
   import tcss_pkg::*;
#(
   parameter int MAX_SPAN   = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [XY_W-1:0]        req_start_x,
   input  logic [XY_W-1:0]        req_row_y,
   input  logic [COUNT_W-1:0]     req_pixel_count,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   push_valid,
   output span_entry_type         push_entry,
   input  logic                   queue_full
);

   localparam int PX_W   = COORD_BITS + 1;
   localparam int XW     = (COORD_BITS > XY_W) ? COORD_BITS : XY_W;
   localparam int MB_W   = (PX_W + 1 > DIFF_W) ? PX_W + 1 : DIFF_W;
   localparam int PROD_W = UV_W + MB_W;
   localparam int ACC_W  = PROD_W + 3;

   localparam logic signed [ACC_W-1:0] COLOR_HALF = ACC_W'(1) << (COLOR_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] STEP_HALF  = ACC_W'(1) << (STEP_SHIFT - 1);
   localparam logic signed [UV_W-1:0]  UV_MAX     = {1'b0, {(UV_W-1){1'b1}}};
   localparam logic signed [UV_W-1:0]  UV_MIN     = {1'b1, {(UV_W-1){1'b0}}};

   function automatic chan_type sat_chan(input logic signed [ACC_W-1:0] v);
      logic ovf;
      ovf = v[ACC_W-1:CHAN_W-1] != {(ACC_W-CHAN_W+1){v[ACC_W-1]}};
      if (!ovf) begin
         return v[CHAN_W-1:0];
      end else if (v[ACC_W-1]) begin
         return CHAN_MIN;
      end else begin
         return CHAN_MAX;
      end
   endfunction

   logic [CSR_DATA_W-1:0] u_gains_ff, v_gains_ff, offsets_ff;
   color_set_type         base_ff, toward_u_ff, toward_v_ff;

   setup_state_type state_ff, state_in;
   logic [PAIR_W-1:0]  pair_ff;
   logic               half_ff;
   logic [PX_W-1:0]    px_ff, py_ff;
   logic [COUNT_W-1:0] count_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [UV_W-1:0]   u17_ff, v17_ff;
   chan_set_type       color_ff, step_ff;

   logic load, mul_en, acc_en, wb_en;

   logic [XW-1:0]         x_wide, y_wide;
   logic [COUNT_W-1:0]    count_clamped;
   logic signed [GAIN_W-1:0] ua, ub, va, vb, uc, vc;
   logic [PAIR_W-1:0]     pair_off;
   logic [1:0]            ch;
   logic                  is_step;
   logic signed [COLOR_W-1:0] c0_cur, c1_cur, c2_cur;
   logic signed [DIFF_W-1:0]  d1_cur, d2_cur;
   logic signed [UV_W-1:0]    a_sel;
   logic signed [MB_W-1:0]    b_sel;
   logic signed [ACC_W-1:0]   init_val;
   logic signed [ACC_W-1:0]   col_rnd, stp_rnd, col_q, stp_q;
   logic                      uv_ovf;
   logic signed [UV_W-1:0]    uv_sat;

   assign ua = u_gains_ff[GAIN_W-1:0];
   assign ub = u_gains_ff[CSR_DATA_W-1:GAIN_W];
   assign va = v_gains_ff[GAIN_W-1:0];
   assign vb = v_gains_ff[CSR_DATA_W-1:GAIN_W];
   assign uc = offsets_ff[GAIN_W-1:0];
   assign vc = offsets_ff[CSR_DATA_W-1:GAIN_W];

   assign x_wide = XW'(req_start_x);
   assign y_wide = XW'(req_row_y);
   assign count_clamped = (req_pixel_count > COUNT_W'(MAX_SPAN)) ? COUNT_W'(MAX_SPAN)
                                                                   : req_pixel_count;

   assign pair_off = pair_ff - PAIR_FIRST_COLOR;
   assign ch       = pair_off[2:1];
   assign is_step  = pair_ff[0];
   assign c0_cur   = base_ff[ch];
   assign c1_cur   = toward_u_ff[ch];
   assign c2_cur   = toward_v_ff[ch];
   assign d1_cur   = DIFF_W'(c1_cur) - DIFF_W'(c0_cur);
   assign d2_cur   = DIFF_W'(c2_cur) - DIFF_W'(c0_cur);

   // operand and accumulator seed for each product pair
   always_comb begin
      priority if (pair_ff == PAIR_U) begin
         a_sel    = half_ff ? UV_W'(ub) : UV_W'(ua);
         b_sel    = half_ff ? MB_W'(py_ff) : MB_W'(px_ff);
         init_val = ACC_W'(uc) <<< 1;
      end else if (pair_ff == PAIR_V) begin
         a_sel    = half_ff ? UV_W'(vb) : UV_W'(va);
         b_sel    = half_ff ? MB_W'(py_ff) : MB_W'(px_ff);
         init_val = ACC_W'(vc) <<< 1;
      end else if (is_step) begin
         a_sel    = half_ff ? UV_W'(va) : UV_W'(ua);
         b_sel    = half_ff ? MB_W'(d2_cur) : MB_W'(d1_cur);
         init_val = '0;
      end else begin
         a_sel    = half_ff ? v17_ff : u17_ff;
         b_sel    = half_ff ? MB_W'(d2_cur) : MB_W'(d1_cur);
         init_val = ACC_W'(c0_cur) <<< UV_FRAC;
      end
   end

   assign uv_ovf = acc_ff[ACC_W-1:UV_W-1] != {(ACC_W-UV_W+1){acc_ff[ACC_W-1]}};
   assign uv_sat = !uv_ovf ? acc_ff[UV_W-1:0] : (acc_ff[ACC_W-1] ? UV_MIN : UV_MAX);
   assign col_rnd = acc_ff + COLOR_HALF;
   assign stp_rnd = acc_ff + STEP_HALF;
   assign col_q   = col_rnd >>> COLOR_SHIFT;
   assign stp_q   = stp_rnd >>> STEP_SHIFT;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC:  state_in = half_ff ? ST_WB : ST_MUL;
         ST_WB:   state_in = (pair_ff == PAIR_LAST) ? ST_PUSH : ST_MUL;
         ST_PUSH: if (!queue_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      load       = 1'b0;
      mul_en     = 1'b0;
      acc_en     = 1'b0;
      wb_en      = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            load      = req_valid;
         end
         ST_MUL:  mul_en = 1'b1;
         ST_ACC:  acc_en = 1'b1;
         ST_WB:   wb_en = 1'b1;
         ST_PUSH: push_valid = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         u_gains_ff  <= '0;
         v_gains_ff  <= '0;
         offsets_ff  <= '0;
         base_ff     <= '0;
         toward_u_ff <= '0;
         toward_v_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_U_GAINS:    u_gains_ff  <= csr_data;
               CSR_V_GAINS:    v_gains_ff  <= csr_data;
               CSR_OFFSETS:    offsets_ff  <= csr_data;
               CSR_COLOR_BASE: base_ff     <= csr_data;
               CSR_COLOR_U:    toward_u_ff <= csr_data;
               CSR_COLOR_V:    toward_v_ff <= csr_data;
               default:        u_gains_ff  <= u_gains_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff    <= {x_wide[COORD_BITS-1:0], 1'b1};
         py_ff    <= {y_wide[COORD_BITS-1:0], 1'b1};
         count_ff <= count_clamped;
         pair_ff  <= PAIR_U;
         half_ff  <= 1'b0;
      end
      if (mul_en) begin
         prod_ff <= a_sel * b_sel;
      end
      if (acc_en) begin
         acc_ff  <= (half_ff ? acc_ff : init_val) + ACC_W'(prod_ff);
         half_ff <= ~half_ff;
      end
      if (wb_en) begin
         if (pair_ff != PAIR_LAST) begin
            pair_ff <= pair_ff + PAIR_W'(1);
         end
         priority if (pair_ff == PAIR_U) begin
            u17_ff <= uv_sat;
         end else if (pair_ff == PAIR_V) begin
            v17_ff <= uv_sat;
         end else if (is_step) begin
            step_ff[ch] <= sat_chan(stp_q);
         end else begin
            color_ff[ch] <= sat_chan(col_q);
         end
      end
   end

   assign push_entry.color = color_ff;
   assign push_entry.step  = step_ff;
   assign push_entry.count = count_ff;

   `TCSS_ASSERT_IMPLIES(a_push_after_all_pairs, clock, reset, state_ff == ST_PUSH, pair_ff == PAIR_LAST, "span pushed before all product pairs were written back")

endmodule

>>> rtl/tcss_queue.sv
// short queue of set-up spans between setup and pixel stages
`include "triangle_color_span_shader_core_macros.svh"
module tcss_queue
   import tcss_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  span_entry_type push_entry,
   output logic           full,
   output logic           pop_valid,
   output span_entry_type pop_entry,
   input  logic           pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   span_entry_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign push      = push_valid && !full;
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `TCSS_ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, count_ff != '0, "span taken from an empty queue")
   `TCSS_ASSERT_IMPLIES(a_fill_in_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue fill beyond its depth")

endmodule

>>> rtl/tcss_pixel.sv
// per-pixel stepping, alpha rounding, premultiply and output register
`include "triangle_color_span_shader_core_macros.svh"
module tcss_pixel
   import tcss_pkg::*;
#(
   parameter int MAX_SPAN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  span_entry_type    q_entry,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ARGB_W-1:0] rsp_pixel_argb,
   output logic              rsp_last_pixel
);

   localparam int CNT_W = $clog2(MAX_SPAN + 1);
   localparam logic signed [PIX_W-1:0] PIX_HALF = PIX_W'(1) << (PIX_SHIFT - 1);

   function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [PIX_W-1:0] v);
      logic big;
      big = |v[PIX_W-2:BYTE_W];
      if (v[PIX_W-1]) begin
         return '0;
      end else if (big) begin
         return '1;
      end else begin
         return v[BYTE_W-1:0];
      end
   endfunction

   chan_set_type      color_ff, step_ff, color_next;
   logic [CNT_W-1:0]  left_ff;
   logic              s1_valid_ff, s1_last_ff;
   logic [BYTE_W-1:0] s1_alpha_ff;
   logic [0:CHANNELS-2][CHAN_W-1:0] s1_rgb_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [ARGB_W-1:0] rsp_argb_ff;

   logic adv, load, emit;
   logic signed [PIX_W-1:0] ca_ext, alpha_sum, alpha_q;
   logic [BYTE_W-1:0]       alpha_byte;
   logic [0:CHANNELS-2][BYTE_W-1:0] rgb_byte;
   logic signed [PIX_W-1:0] alpha_s;
   logic signed [CHAN_W:0]  step_sum [CHANNELS];
   logic signed [PIX_W-1:0] pm_prod [CHANNELS-1];

   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign load  = (left_ff == '0) && q_valid;
   assign emit  = (left_ff != '0) && adv;
   assign q_pop = load;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         step_sum[i] = (CHAN_W + 1)'($signed(color_ff[i])) +
                       (CHAN_W + 1)'($signed(step_ff[i]));
         if (step_sum[i][CHAN_W] != step_sum[i][CHAN_W-1]) begin
            color_next[i] = step_sum[i][CHAN_W] ? CHAN_MIN : CHAN_MAX;
         end else begin
            color_next[i] = step_sum[i][CHAN_W-1:0];
         end
      end
   end

   // alpha times 255 as a shift and subtract
   assign ca_ext     = PIX_W'($signed(color_ff[0]));
   assign alpha_sum  = (ca_ext <<< BYTE_W) - ca_ext + PIX_HALF;
   assign alpha_q    = alpha_sum >>> PIX_SHIFT;
   assign alpha_byte = clamp_byte(alpha_q);

   assign alpha_s = PIX_W'($signed({1'b0, s1_alpha_ff}));

   always_comb begin
      for (int i = 0; i < CHANNELS - 1; i++) begin
         pm_prod[i]  = alpha_s * PIX_W'($signed(s1_rgb_ff[i])) + PIX_HALF;
         rgb_byte[i] = clamp_byte(pm_prod[i] >>> PIX_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            left_ff <= CNT_W'(q_entry.count);
         end else if (emit) begin
            left_ff <= left_ff - CNT_W'(1);
         end
         if (adv) begin
            s1_valid_ff  <= emit;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         color_ff <= q_entry.color;
         step_ff  <= q_entry.step;
      end else if (emit) begin
         color_ff <= color_next;
      end
      if (adv) begin
         s1_alpha_ff <= alpha_byte;
         s1_last_ff  <= left_ff == CNT_W'(1);
         for (int i = 0; i < CHANNELS - 1; i++) begin
            s1_rgb_ff[i] <= color_ff[i+1];
         end
         rsp_argb_ff <= {s1_alpha_ff, rgb_byte[0], rgb_byte[1], rgb_byte[2]};
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_argb = rsp_argb_ff;
   assign rsp_last_pixel = rsp_last_ff;

   `TCSS_ASSERT_IMPLIES(a_mid_span_pending, clock, reset, s1_valid_ff && !s1_last_ff, left_ff != '0, "non-final pixel in flight with nothing left to emit")
   `TCSS_ASSERT_NEXT(a_last_marked, clock, reset, emit && (left_ff == CNT_W'(1)), s1_valid_ff && s1_last_ff, "final pixel of a span not marked last")

endmodule
